// ===== sv/lkvc_pkg.sv =====
`default_nettype none

package lkvc_pkg;

   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int CAP_BITS   = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef struct packed {
      logic                  operation;
      logic [KEY_BITS-1:0]   lookup_key;
      logic [VALUE_BITS-1:0] put_value;
   } req_type;

   typedef struct packed {
      logic                  found;
      logic [VALUE_BITS-1:0] read_value;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_TOUCH,
      CMD_FILL,
      CMD_REPLACE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type            op;
      logic                  write;
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic                  hit;
      logic [VALUE_BITS-1:0] value;
      logic                  free_seen;
   } link_type;

endpackage

`default_nettype wire

// ===== sv/lkvc_cell.sv =====
`default_nettype none

module lkvc_cell
   import lkvc_pkg::*;
#(
   parameter int RANK_BITS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 compare_en,
   input  wire logic [KEY_BITS-1:0]  search_key,
   input  wire logic [RANK_BITS-1:0] lru_rank,
   input  wire link_type             prev_link,
   input  wire logic [RANK_BITS-1:0] prev_rank,
   output link_type                  next_link,
   output logic [RANK_BITS-1:0]      next_rank,
   input  wire logic                 update_en,
   input  wire cmd_type              cmd,
   input  wire logic [RANK_BITS-1:0] ref_rank
);

   logic                  valid_ff, valid_in;
   logic [RANK_BITS-1:0]  rank_ff, rank_in;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  match_ff, lru_ff, free_ff;
   logic                  mine_hit, target, bump;

   always_comb begin
      mine_hit            = valid_ff && (key_ff == search_key);
      next_link.hit       = prev_link.hit | mine_hit;
      next_link.value     = prev_link.value | (mine_hit ? value_ff : '0);
      next_link.free_seen = prev_link.free_seen | !valid_ff;
      next_rank           = prev_rank | (mine_hit ? rank_ff : '0);
   end

   always_comb begin
      unique case (cmd.op)
         CMD_TOUCH: begin
            target = match_ff;
            bump   = valid_ff && !match_ff && (rank_ff < ref_rank);
         end
         CMD_REPLACE: begin
            target = lru_ff;
            bump   = valid_ff && !lru_ff && (rank_ff < ref_rank);
         end
         CMD_FILL: begin
            target = free_ff;
            bump   = valid_ff;
         end
         CMD_NONE: begin
            target = 1'b0;
            bump   = 1'b0;
         end
      endcase
      valid_in = valid_ff;
      rank_in  = rank_ff;
      if (update_en && target) begin
         valid_in = 1'b1;
         rank_in  = '0;
      end else if (update_en && bump) begin
         rank_in = rank_ff + RANK_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (compare_en) begin
         match_ff <= mine_hit;
         lru_ff   <= valid_ff && (rank_ff == lru_rank);
         free_ff  <= !valid_ff && !prev_link.free_seen;
      end
      if (update_en && target && cmd.write) begin
         key_ff   <= cmd.key;
         value_ff <= cmd.value;
      end
   end

endmodule

`default_nettype wire

// ===== sv/lru_key_value_cache.sv =====
// A get's response word is registered in the update phase, after the compare phase
// has registered the hit. Each request takes a compare phase then an update phase
// across the row of entry cells; a new request is taken during update, not compare.
// A get waits in update while the response is stalled. Puts give no response word.
// Reset: synchronous; clears every entry's valid bit and rank, the fill count
// and sets capacity to 16. Stored keys and values are not cleared.
`default_nettype none

module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_type             req_word,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_word,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [CAP_BITS-1:0] csr_data
);

   localparam int RANK_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);
   localparam int CMP_BITS  = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_COMPARE,
      PH_UPDATE
   } phase_type;

   phase_type             phase_ff;
   req_type               req_ff;
   logic                  hit_ff;
   logic [VALUE_BITS-1:0] hit_value_ff;
   logic [RANK_BITS-1:0]  hit_rank_ff;
   logic [CNT_BITS-1:0]   fill_count_ff;
   logic [CAP_BITS-1:0]   capacity_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_word_ff;

   link_type              links [DEPTH+1];
   logic [RANK_BITS-1:0]  ranks [DEPTH+1];

   logic                  accept, compare_en, update_en, update_go;
   logic [CMP_BITS-1:0]   usable_cap, cap_wide;
   logic [RANK_BITS-1:0]  lru_rank, ref_rank;
   cmd_type               cmd;

   assign links[0]  = '0;
   assign ranks[0]  = '0;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      cap_wide   = CMP_BITS'(capacity_ff);
      usable_cap = cap_wide;
      if (cap_wide == '0) begin
         usable_cap = CMP_BITS'(1);
      end else if (cap_wide > CMP_BITS'(DEPTH)) begin
         usable_cap = CMP_BITS'(DEPTH);
      end
      lru_rank = RANK_BITS'(fill_count_ff - CNT_BITS'(1));

      cmd.write = (req_ff.operation == OP_PUT);
      cmd.key   = req_ff.lookup_key;
      cmd.value = req_ff.put_value;
      ref_rank  = hit_rank_ff;
      if (hit_ff) begin
         cmd.op = CMD_TOUCH;
      end else if (req_ff.operation == OP_GET) begin
         cmd.op = CMD_NONE;
      end else if (CMP_BITS'(fill_count_ff) < usable_cap) begin
         cmd.op = CMD_FILL;
      end else begin
         cmd.op   = CMD_REPLACE;
         ref_rank = lru_rank;
      end

      update_go  = (req_ff.operation == OP_PUT) || !rsp_valid_ff || !rsp_stall;
      compare_en = (phase_ff == PH_COMPARE);
      update_en  = (phase_ff == PH_UPDATE) && update_go;
      req_stall  = compare_en || ((phase_ff == PH_UPDATE) && !update_go);
      accept     = req_valid && !req_stall;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      lkvc_cell #(
         .RANK_BITS (RANK_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .compare_en (compare_en),
         .search_key (req_ff.lookup_key),
         .lru_rank   (lru_rank),
         .prev_link  (links[i]),
         .prev_rank  (ranks[i]),
         .next_link  (links[i+1]),
         .next_rank  (ranks[i+1]),
         .update_en  (update_en),
         .cmd        (cmd),
         .ref_rank   (ref_rank)
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         rsp_valid_ff  <= 1'b0;
         fill_count_ff <= '0;
         capacity_ff   <= CAP_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_data;
         end
         unique case (phase_ff)
            PH_IDLE: begin
               if (accept) begin
                  phase_ff <= PH_COMPARE;
               end
            end
            PH_COMPARE: begin
               phase_ff <= PH_UPDATE;
            end
            PH_UPDATE: begin
               if (accept) begin
                  phase_ff <= PH_COMPARE;
               end else if (update_go) begin
                  phase_ff <= PH_IDLE;
               end
            end
         endcase
         if (update_en && (cmd.op == CMD_FILL)) begin
            fill_count_ff <= fill_count_ff + CNT_BITS'(1);
         end
         if (update_en && (req_ff.operation == OP_GET)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
      end
      if (compare_en) begin
         hit_ff       <= links[DEPTH].hit;
         hit_value_ff <= links[DEPTH].value;
         hit_rank_ff  <= ranks[DEPTH];
      end
      if (update_en && (req_ff.operation == OP_GET)) begin
         rsp_word_ff.found      <= hit_ff;
         rsp_word_ff.read_value <= hit_value_ff;
      end
   end

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_BITS'(DEPTH))
      else $error("fill count beyond depth");

   a_accept_then_compare: assert property (@(posedge clock) disable iff (reset)
      accept |=> (phase_ff == PH_COMPARE) && req_stall)
      else $error("accepted word not followed by compare");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(phase_ff == PH_UPDATE))
      else $error("response raised outside update");

   a_fill_needs_miss: assert property (@(posedge clock) disable iff (reset)
      (update_en && (cmd.op == CMD_FILL)) |-> !hit_ff && (req_ff.operation == OP_PUT))
      else $error("fill issued on hit or get");
`endif

endmodule

`default_nettype wire

// ===== tb/lru_key_value_cache_tb.sv =====
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
   import lkvc_pkg::*;

   localparam int DEPTH = 16;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_word = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_word;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CAP_BITS-1:0] csr_data = '0;

   logic [KEY_BITS-1:0]   cache_key   [DEPTH];
   logic [VALUE_BITS-1:0] cache_value [DEPTH];
   int unsigned           cache_rank  [DEPTH];
   int unsigned           cache_fill;
   logic [CAP_BITS-1:0]   cache_capacity;
   rsp_type               pending_reads[$];
   rsp_type               next_read;

   int send_idle_pct;
   int stall_pct;
   int error_count;
   int reads_checked;
   int hits_checked;
   int writes_sent;
   int evictions;

   lru_key_value_cache #(.DEPTH(DEPTH)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic void promote_entry(int slot);
      int unsigned r;
      r = cache_rank[slot];
      for (int i = 0; i < cache_fill; i++) begin
         if (cache_rank[i] < r) cache_rank[i]++;
      end
      cache_rank[slot] = 0;
   endfunction

   function automatic void expect_read(rsp_type r);
      pending_reads.insert(pending_reads.size(), r);
   endfunction

   function automatic void cache_apply(req_type w);
      int          slot;
      int unsigned usable;
      int unsigned oldest;
      slot = -1;
      for (int i = 0; i < cache_fill; i++) begin
         if (slot < 0 && cache_key[i] == w.lookup_key) slot = i;
      end
      if (w.operation == OP_GET) begin
         if (slot >= 0) begin
            expect_read(rsp_type'{found: 1'b1, read_value: cache_value[slot]});
            promote_entry(slot);
         end else begin
            expect_read(rsp_type'{found: 1'b0, read_value: '0});
         end
         return;
      end
      writes_sent++;
      if (slot >= 0) begin
         cache_value[slot] = w.put_value;
         promote_entry(slot);
         return;
      end
      usable = (cache_capacity == 0) ? 1 :
               (cache_capacity > DEPTH) ? DEPTH : int'(cache_capacity);
      if (cache_fill < usable) begin
         for (int i = 0; i < cache_fill; i++) cache_rank[i]++;
         cache_key[cache_fill]   = w.lookup_key;
         cache_value[cache_fill] = w.put_value;
         cache_rank[cache_fill]  = 0;
         cache_fill++;
      end else begin
         slot   = 0;
         oldest = 0;
         for (int i = 0; i < cache_fill; i++) begin
            if (cache_rank[i] > oldest) begin
               oldest = cache_rank[i];
               slot   = i;
            end
         end
         cache_key[slot]   = w.lookup_key;
         cache_value[slot] = w.put_value;
         promote_entry(slot);
         evictions++;
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reads.size() == 0) begin
            report_mismatch("unexpected response", rsp_word.read_value, '0);
         end else begin
            next_read = pending_reads.pop_front();
            if (rsp_word.found !== next_read.found)
               report_mismatch("found", 32'(rsp_word.found), 32'(next_read.found));
            if (rsp_word.read_value !== next_read.read_value)
               report_mismatch("read_value", rsp_word.read_value, next_read.read_value);
            reads_checked++;
            if (next_read.found) hits_checked++;
         end
      end
   end

   task automatic send_word(logic op, logic [KEY_BITS-1:0] key, logic [VALUE_BITS-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_word  <= req_type'{operation: op, lookup_key: key, put_value: value};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      cache_apply(req_type'{operation: op, lookup_key: key, put_value: value});
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_BITS-1:0] cap);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cache_capacity = cap;
   endtask

   task automatic test_empty_miss();
      send_word(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
   endtask

   task automatic test_put_get_extremes();
      send_word(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
      send_word(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(OP_GET, 32'h0000_0000, 32'h1234_5678);
      send_word(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(OP_PUT, 32'h0000_0000, 32'h5A5A_A5A5);
      send_word(OP_GET, 32'h0000_0000, 32'h0000_0000);
   endtask

   task automatic test_lru_replace();
      write_capacity(5'd2);
      send_word(OP_PUT, 32'hA000_0001, 32'h1111_1111);
      send_word(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
      send_word(OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_word(OP_GET, 32'hDEAD_BEEF, 32'h0000_0000);
      send_word(OP_PUT, 32'hB000_0002, 32'h2222_2222);
      send_word(OP_GET, 32'hA000_0001, 32'h0000_0000);
      send_word(OP_GET, 32'hB000_0002, 32'h0000_0000);
   endtask

   task automatic test_capacity_shrink();
      write_capacity(5'd16);
      send_word(OP_PUT, 32'hC000_0003, 32'h3333_3333);
      send_word(OP_PUT, 32'hC000_0004, 32'h4444_4444);
      send_word(OP_PUT, 32'hC000_0005, 32'h5555_5555);
      write_capacity(5'd1);
      send_word(OP_PUT, 32'hD000_0006, 32'h6666_6666);
      send_word(OP_GET, 32'hD000_0006, 32'h0000_0000);
   endtask

   task automatic test_capacity_bounds();
      write_capacity(5'd0);
      send_word(OP_PUT, 32'hE000_0007, 32'h7777_7777);
      send_word(OP_GET, 32'hE000_0007, 32'h0000_0000);
      write_capacity(5'd31);
      send_word(OP_PUT, 32'hF000_0008, 32'h8888_8888);
   endtask

   task automatic test_random_traffic();
      logic [CAP_BITS-1:0] caps [8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2, 5'd16, 5'd9};
      logic [KEY_BITS-1:0] key_pool [32];
      logic [KEY_BITS-1:0] key;
      int                  usable;
      int                  pool_size;
      for (int p = 0; p < 8; p++) begin
         write_capacity(caps[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 78; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 78; end
            default: begin send_idle_pct = 16; stall_pct = 16; end
         endcase
         usable    = (caps[p] == 0) ? 1 : (caps[p] > DEPTH) ? DEPTH : int'(caps[p]);
         pool_size = usable + usable / 2 + 1;
         for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom;
         for (int n = 0; n < 170; n++) begin
            if (n == 85) wait_idle();
            key = ($urandom_range(9) == 0) ? $urandom :
                  key_pool[5'($urandom_range(pool_size - 1))];
            send_word(1'($urandom_range(1)), key, $urandom);
         end
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   initial begin
      cache_fill     = 0;
      cache_capacity = CAP_RESET;
      for (int i = 0; i < DEPTH; i++) cache_rank[i] = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_miss();
      test_put_get_extremes();
      test_lru_replace();
      test_capacity_shrink();
      test_capacity_bounds();
      test_random_traffic();
      wait_idle();
      repeat (8) @(posedge clock);
      $display("Checked %0d lookups (%0d hits) and %0d stores with %0d replacements,",
               reads_checked, hits_checked, writes_sent, evictions);
      $display("over capacities 0 to 31, with sender gaps and response stalls mixed in.");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
